[hw/rtl/dilp_pkg.sv]
// Shared types, constants and base64 digit lookup for the index line parser.
`default_nettype none

package dilp_pkg;

    typedef enum logic [1:0] {
        FIELD_WORD   = 2'd0,
        FIELD_OFFSET = 2'd1,
        FIELD_SIZE   = 2'd2
    } field_sel_t;

    localparam logic       KIND_WORD   = 1'b0;
    localparam logic       KIND_RECORD = 1'b1;

    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_NL     = 8'h0A;
    localparam logic [6:0] DIGIT_MISS  = 7'd64;
    localparam logic [7:0] LEN_MAX     = 8'd255;

    typedef struct packed {
        logic        kind;
        logic [7:0]  word_byte;
        logic [7:0]  word_len;
        logic [31:0] offset;
        logic [31:0] size;
    } dilp_result_t;

    // Map one byte through the standard base64 alphabet; anything else is 64.
    function automatic logic [6:0] dilp_digit(input logic [7:0] b);
        logic [6:0] d;
        d = DIGIT_MISS;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            d = 7'(b - 8'h41);
        end
        else if (b >= 8'h61 && b <= 8'h7A)
        begin
            d = 7'(b - 8'h61 + 8'd26);
        end
        else if (b >= 8'h30 && b <= 8'h39)
        begin
            d = 7'(b - 8'h30 + 8'd52);
        end
        else if (b == 8'h2B)
        begin
            d = 7'd62;
        end
        else if (b == 8'h2F)
        begin
            d = 7'd63;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dilp_parse_step.sv]
// Combinational parse step: next field, counters, accumulators and result for one byte.
`default_nettype none

module dilp_parse_step
    import dilp_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  wire logic [7:0]           byte_in,
    input  wire field_sel_t           field_cur,
    input  wire logic [7:0]           word_len_cur,
    input  wire logic [ACC_WIDTH-1:0] offset_cur,
    input  wire logic [ACC_WIDTH-1:0] size_cur,
    output field_sel_t                field_nxt,
    output logic [7:0]                word_len_nxt,
    output logic [ACC_WIDTH-1:0]      offset_nxt,
    output logic [ACC_WIDTH-1:0]      size_nxt,
    output logic                      has_result,
    output dilp_result_t              result
);

    logic                 is_tab;
    logic                 is_nl;
    logic [6:0]           digit;
    logic [7:0]           len_sat;
    logic [ACC_WIDTH-1:0] offset_acc;
    logic [ACC_WIDTH-1:0] size_acc;

    assign is_tab     = (byte_in == BYTE_TAB);
    assign is_nl      = (byte_in == BYTE_NL);
    assign digit      = dilp_digit(byte_in);
    assign len_sat    = (word_len_cur == LEN_MAX) ? word_len_cur : word_len_cur + 8'd1;
    // acc * 64 + digit, wrapping at the accumulator width
    assign offset_acc = (offset_cur << 6) + ACC_WIDTH'(digit);
    assign size_acc   = (size_cur << 6) + ACC_WIDTH'(digit);

    always_comb
    begin
        field_nxt = field_cur;
        unique case (field_cur)
            FIELD_WORD:
            begin
                if (is_tab)
                begin
                    field_nxt = FIELD_OFFSET;
                end
            end
            FIELD_OFFSET:
            begin
                if (is_tab)
                begin
                    field_nxt = FIELD_SIZE;
                end
            end
            default:
            begin
                if (is_nl)
                begin
                    field_nxt = FIELD_WORD;
                end
            end
        endcase
    end

    always_comb
    begin
        word_len_nxt = word_len_cur;
        offset_nxt   = offset_cur;
        size_nxt     = size_cur;
        has_result   = 1'b0;
        result       = '0;
        unique case (field_cur)
            FIELD_WORD:
            begin
                if (!is_tab)
                begin
                    word_len_nxt     = len_sat;
                    has_result       = 1'b1;
                    result.kind      = KIND_WORD;
                    result.word_byte = byte_in;
                    result.word_len  = len_sat;
                end
            end
            FIELD_OFFSET:
            begin
                if (!is_tab)
                begin
                    offset_nxt = offset_acc;
                end
            end
            default:
            begin
                if (!is_nl)
                begin
                    size_nxt = size_acc;
                end
                else
                begin
                    has_result      = 1'b1;
                    result.kind     = KIND_RECORD;
                    result.word_len = word_len_cur;
                    result.offset   = 32'(offset_cur);
                    result.size     = 32'(size_cur);
                    // record done: back to the reset state
                    word_len_nxt    = '0;
                    offset_nxt      = '0;
                    size_nxt        = '0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/dict_index_line_parser_core.sv]
// An input transfer loads the input register; once the result register is free,
// the parse step takes that byte and any result goes into the result register.
// Throughput: one byte per cycle; an input register and a result register
// with stall-aware advance let a byte enter every cycle while out_ready is high.
// Tabs and numeric digits yield no result; a line's closing newline yields a record.
// Reset (rst_n low, asynchronous): both stages empty, headword field, counters zero.
`default_nettype none

module dict_index_line_parser_core
    import dilp_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       headword_byte,
    output logic [7:0]       headword_length,
    output logic [31:0]      offset_value,
    output logic [31:0]      size_value
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [7:0]           s1_byte_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    dilp_result_t         out_data_reg;

    field_sel_t           field_reg;
    field_sel_t           field_next;
    logic [7:0]           word_len_reg;
    logic [7:0]           word_len_next;
    logic [ACC_WIDTH-1:0] offset_reg;
    logic [ACC_WIDTH-1:0] offset_next;
    logic [ACC_WIDTH-1:0] size_reg;
    logic [ACC_WIDTH-1:0] size_next;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_xfer;
    logic                 step_has_result;
    dilp_result_t         step_result;

    dilp_parse_step #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_step (
        .byte_in     (s1_byte_reg),
        .field_cur   (field_reg),
        .word_len_cur(word_len_reg),
        .offset_cur  (offset_reg),
        .size_cur    (size_reg),
        .field_nxt   (field_next),
        .word_len_nxt(word_len_next),
        .offset_nxt  (offset_next),
        .size_nxt    (size_next),
        .has_result  (step_has_result),
        .result      (step_result)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_xfer  = in_valid && in_ready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_adv);
    assign out_valid_next = (out_valid_reg && !out_ready) || (s1_adv && step_has_result);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            field_reg     <= FIELD_WORD;
            word_len_reg  <= '0;
            offset_reg    <= '0;
            size_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                field_reg    <= field_next;
                word_len_reg <= word_len_next;
                offset_reg   <= offset_next;
                size_reg     <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_adv && step_has_result)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_data_reg.kind;
    assign headword_byte   = out_data_reg.word_byte;
    assign headword_length = out_data_reg.word_len;
    assign offset_value    = out_data_reg.offset;
    assign size_value      = out_data_reg.size;

endmodule

`default_nettype wire

[hw/rtl/dilp_checker.sv]
// Port-level checker for the index line parser, bound to the top level.
`default_nettype none

module dilp_checker
    import dilp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic [7:0]  headword_byte,
    input wire logic [7:0]  headword_length,
    input wire logic [31:0] offset_value,
    input wire logic [31:0] size_value
);

    // hold a stalled result until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(headword_byte) && $stable(headword_length)
            && $stable(offset_value) && $stable(size_value))
        else $error("stalled result changed");

    a_word_no_numbers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_WORD |-> offset_value == 32'd0 && size_value == 32'd0)
        else $error("headword result carries offset or size");

    a_record_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_RECORD |-> headword_byte == 8'd0)
        else $error("record result carries a headword byte");

    a_word_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_WORD |-> headword_length != 8'd0)
        else $error("headword result with zero length");

endmodule

bind dict_index_line_parser_core dilp_checker u_dilp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .headword_byte  (headword_byte),
    .headword_length(headword_length),
    .offset_value   (offset_value),
    .size_value     (size_value)
);

`default_nettype wire
